@@ design/dfsw_pkg.sv @@
// shared types, constants and command codes for the directory file-size walker
`default_nettype none

package dfsw_pkg;

  // directory geometry
  localparam int unsigned ENTRIES      = 160;
  localparam int unsigned ENTRY_BYTES  = 25;
  localparam int unsigned MEM_DEPTH    = ENTRIES * ENTRY_BYTES;
  localparam int unsigned ADDR_W       = $clog2(MEM_DEPTH);
  localparam int unsigned HOP_W        = $clog2(ENTRIES + 1);

  // field widths
  localparam int unsigned ENTRY_W      = 8;
  localparam int unsigned POS_W        = 5;
  localparam int unsigned SIZE_W       = 27;
  localparam int unsigned STATUS_W     = 2;

  // entry layout
  localparam logic [POS_W-1:0] FIRST_EXTENT = POS_W'(12);
  localparam logic [POS_W-1:0] LAST_EXTENT  = POS_W'(21);
  localparam logic [POS_W-1:0] CONT_EXTENT  = POS_W'(1);
  localparam logic [POS_W-1:0] LINK_BYTE    = POS_W'(24);
  localparam logic [POS_W-1:0] FLAG_BYTE    = POS_W'(0);
  localparam logic [POS_W-1:0] EXTENT_BYTES = POS_W'(3);
  localparam int unsigned      FLAG_CONTINUED_BIT = 5;  // 0x20
  localparam int unsigned      FLAG_IS_CONT_BIT   = 0;  // 0x01
  localparam int unsigned      SECTOR_BYTES = 256;

  // actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // walk status codes
  localparam logic [STATUS_W-1:0] WS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] WS_CORRUPT = 2'd1;
  localparam logic [STATUS_W-1:0] WS_HOPS    = 2'd2;

  // read offset select
  localparam logic [2:0] OFF_POS  = 3'd0;
  localparam logic [2:0] OFF_POS1 = 3'd1;
  localparam logic [2:0] OFF_POS2 = 3'd2;
  localparam logic [2:0] OFF_NEXT = 3'd3;
  localparam logic [2:0] OFF_FLAG = 3'd4;
  localparam logic [2:0] OFF_LINK = 3'd5;
  localparam logic [2:0] OFF_CONT = 3'd6;

  // read entry select
  localparam logic [1:0] ENT_IN    = 2'd0;
  localparam logic [1:0] ENT_CUR   = 2'd1;
  localparam logic [1:0] ENT_NXT   = 2'd2;
  localparam logic [1:0] ENT_RDATA = 2'd3;

  typedef struct packed {
    logic               action;
    logic [ENTRY_W-1:0] entry_index;
    logic [4:0]         byte_offset;
    logic [7:0]         byte_value;
  } in_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size_bytes;
    logic [STATUS_W-1:0] walk_status;
    logic [7:0]          entry_flags;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic                mem_we;
    logic                rd_en;
    logic [1:0]          rd_ent;
    logic [2:0]          rd_off;
    logic                start;
    logic                start_bad;
    logic                ld_flags;
    logic                ld_hi;
    logic                ld_lo;
    logic                acc;
    logic                ld_last;
    logic                ld_nxt;
    logic                hop;
    logic                set_status;
    logic [STATUS_W-1:0] status_val;
    logic                fin;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_query;
    logic idx_ok;
    logic wr_ok;
    logic ext_zero;
    logic ext_last;
    logic flag_cont;
    logic link_bad;
    logic is_cont;
    logic hop_full;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ design/disk_directory_file_size_walker_unit.sv @@
// top level of the directory file-size walker: sequencer plus datapath
//
//   channel  direction  handshake               item type
//   in       input      in_valid_i / in_ready_o    dfsw_pkg::in_item_t
//   out      output     out_valid_o / out_ready_i  dfsw_pkg::out_item_t
//
// a write item stores one byte when its entry and offset are in range; it gives no result
// a query reads the flag byte, then each extent (the all-zero one too) and, per followed
//   link, the link byte and next flag, at most one store byte read per cycle, then closes
//   the walk; a query naming an entry past the end answers corrupt with zero size and flags
// reset clears the sequencer and the result valid flag; the store is not cleared
// a query waits in its last step while the result register still holds an
//   untaken item; writes are taken whenever the sequencer is idle
`default_nettype none

module disk_directory_file_size_walker_unit (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire dfsw_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dfsw_pkg::out_item_t      out_item_o
);
  import dfsw_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: steps through flag, extent bytes, link and trim reads
  dfsw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: directory store, size accumulator, trim and result register
  dfsw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

@@ design/dfsw_datapath.sv @@
// directory store, walk registers, trim and result register
`default_nettype none

module dfsw_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dfsw_pkg::in_item_t in_item_i,
  input  wire dfsw_pkg::dp_cmd_t  cmd_i,
  output dfsw_pkg::dp_stat_t      stat_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output dfsw_pkg::out_item_t     out_item_o
);
  import dfsw_pkg::*;

  logic [7:0]          mem [MEM_DEPTH];
  logic [7:0]          rdata_q;
  logic [ENTRY_W-1:0]  cur_q, nxt_q;
  logic [POS_W-1:0]    pos_q;
  logic [HOP_W-1:0]    hops_q;
  logic [SIZE_W-1:0]   size_q;
  logic [7:0]          hi_q, lo_q, last_q, flags_q;
  logic [STATUS_W-1:0] status_q;
  out_item_t           out_q;
  logic                out_valid_q;

  logic [ENTRY_W-1:0]  rd_entry;
  logic [POS_W-1:0]    rd_pos;
  logic [ADDR_W-1:0]   rd_addr, wr_addr;
  logic [POS_W-1:0]    pos_next;
  logic [8:0]          trim_sub;
  logic [SIZE_W-1:0]   final_size;

  assign pos_next = pos_q + EXTENT_BYTES;

  always_comb begin
    unique case (cmd_i.rd_ent)
      ENT_IN:  rd_entry = in_item_i.entry_index;
      ENT_CUR: rd_entry = cur_q;
      ENT_NXT: rd_entry = nxt_q;
      default: rd_entry = rdata_q;
    endcase
  end

  always_comb begin
    unique case (cmd_i.rd_off)
      OFF_POS:  rd_pos = pos_q;
      OFF_POS1: rd_pos = pos_q + POS_W'(1);
      OFF_POS2: rd_pos = pos_q + POS_W'(2);
      OFF_NEXT: rd_pos = pos_next;
      OFF_FLAG: rd_pos = FLAG_BYTE;
      OFF_LINK: rd_pos = LINK_BYTE;
      OFF_CONT: rd_pos = CONT_EXTENT;
      default:  rd_pos = FLAG_BYTE;
    endcase
  end

  // entry * 25 + offset, constant multiply
  assign rd_addr = ADDR_W'(rd_entry) * ADDR_W'(ENTRY_BYTES) + ADDR_W'(rd_pos);
  assign wr_addr = ADDR_W'(in_item_i.entry_index) * ADDR_W'(ENTRY_BYTES)
                 + ADDR_W'(in_item_i.byte_offset);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) begin
      mem[wr_addr] <= in_item_i.byte_value;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // trim by last-sector byte count, zero means full sector
  assign trim_sub = 9'(SECTOR_BYTES) - {1'b0, last_q};
  always_comb begin
    if (last_q == 8'd0) begin
      final_size = size_q;
    end else if (size_q > SIZE_W'(trim_sub)) begin
      final_size = size_q - SIZE_W'(trim_sub);
    end else begin
      final_size = '0;
    end
  end

  // walk registers; the largest reachable sum stays below 2^27
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cur_q    <= in_item_i.entry_index;
      pos_q    <= FIRST_EXTENT;
      hops_q   <= '0;
      size_q   <= '0;
      status_q <= WS_OK;
    end
    if (cmd_i.start_bad) begin
      size_q   <= '0;
      last_q   <= '0;
      flags_q  <= '0;
      status_q <= WS_CORRUPT;
    end
    if (cmd_i.ld_flags) flags_q <= rdata_q;
    if (cmd_i.ld_hi)    hi_q    <= rdata_q;
    if (cmd_i.ld_lo)    lo_q    <= rdata_q;
    if (cmd_i.acc) begin
      size_q <= size_q + SIZE_W'({rdata_q, 8'h00});
      pos_q  <= pos_next;
    end
    if (cmd_i.ld_last) last_q <= rdata_q;
    if (cmd_i.ld_nxt)  nxt_q  <= rdata_q;
    if (cmd_i.hop) begin
      cur_q  <= nxt_q;
      pos_q  <= CONT_EXTENT;
      hops_q <= hops_q + HOP_W'(1);
    end
    if (cmd_i.set_status) status_q <= cmd_i.status_val;
    if (cmd_i.fin) begin
      out_q.size_bytes  <= final_size;
      out_q.walk_status <= status_q;
      out_q.entry_flags <= flags_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    stat_o.is_query  = (in_item_i.action == ACT_QUERY);
    stat_o.idx_ok    = ({1'b0, in_item_i.entry_index} < 9'(ENTRIES));
    stat_o.wr_ok     = stat_o.idx_ok && (in_item_i.byte_offset < 5'(ENTRY_BYTES));
    stat_o.ext_zero  = (hi_q == 8'd0) && (lo_q == 8'd0) && (rdata_q == 8'd0);
    stat_o.ext_last  = (pos_next > LAST_EXTENT);
    stat_o.flag_cont = rdata_q[FLAG_CONTINUED_BIT];
    stat_o.link_bad  = ({1'b0, rdata_q} >= 9'(ENTRIES));
    stat_o.is_cont   = rdata_q[FLAG_IS_CONT_BIT];
    stat_o.hop_full  = ({1'b0, hops_q} >= (HOP_W + 1)'(ENTRIES));
    stat_o.out_busy  = out_valid_q && !out_ready_i;
  end

endmodule

`default_nettype wire

@@ design/dfsw_ctrl.sv @@
// walk sequencer: issues at most one store read per cycle and steers the datapath
`default_nettype none

module dfsw_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire dfsw_pkg::dp_stat_t stat_i,
  output dfsw_pkg::dp_cmd_t       cmd_o
);
  import dfsw_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RFLAG  = 4'd1;
  localparam logic [3:0] S_RHI    = 4'd2;
  localparam logic [3:0] S_RLO    = 4'd3;
  localparam logic [3:0] S_RCNT   = 4'd4;
  localparam logic [3:0] S_RCFLAG = 4'd5;
  localparam logic [3:0] S_RLINK  = 4'd6;
  localparam logic [3:0] S_RNFLAG = 4'd7;
  localparam logic [3:0] S_TRIM   = 4'd8;
  localparam logic [3:0] S_FIN    = 4'd9;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (!stat_i.is_query) begin
            cmd_o.mem_we = stat_i.wr_ok;
          end else if (stat_i.idx_ok) begin
            cmd_o.start  = 1'b1;
            cmd_o.rd_en  = 1'b1;
            cmd_o.rd_ent = ENT_IN;
            cmd_o.rd_off = OFF_FLAG;
            state_d      = S_RFLAG;
          end else begin
            cmd_o.start_bad = 1'b1;
            state_d         = S_FIN;
          end
        end
      end
      S_RFLAG: begin
        cmd_o.ld_flags = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_ent   = ENT_CUR;
        cmd_o.rd_off   = OFF_POS;
        state_d        = S_RHI;
      end
      S_RHI: begin
        cmd_o.ld_hi  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_ent = ENT_CUR;
        cmd_o.rd_off = OFF_POS1;
        state_d      = S_RLO;
      end
      S_RLO: begin
        cmd_o.ld_lo  = 1'b1;
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_ent = ENT_CUR;
        cmd_o.rd_off = OFF_POS2;
        state_d      = S_RCNT;
      end
      S_RCNT: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_ent = ENT_CUR;
        if (stat_i.ext_zero) begin
          cmd_o.rd_off = OFF_LINK;
          state_d      = S_TRIM;
        end else begin
          cmd_o.acc = 1'b1;
          if (stat_i.ext_last) begin
            cmd_o.rd_off = OFF_FLAG;
            state_d      = S_RCFLAG;
          end else begin
            cmd_o.rd_off = OFF_NEXT;
            state_d      = S_RHI;
          end
        end
      end
      S_RCFLAG: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_ent = ENT_CUR;
        cmd_o.rd_off = OFF_LINK;
        state_d      = stat_i.flag_cont ? S_RLINK : S_TRIM;
      end
      S_RLINK: begin
        cmd_o.ld_last = 1'b1;
        cmd_o.ld_nxt  = 1'b1;
        if (stat_i.link_bad) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = WS_CORRUPT;
          state_d          = S_FIN;
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_ent = ENT_RDATA;
          cmd_o.rd_off = OFF_FLAG;
          state_d      = S_RNFLAG;
        end
      end
      S_RNFLAG: begin
        if (!stat_i.is_cont) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = WS_CORRUPT;
          state_d          = S_FIN;
        end else if (stat_i.hop_full) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status_val = WS_HOPS;
          state_d          = S_FIN;
        end else begin
          cmd_o.hop    = 1'b1;
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_ent = ENT_NXT;
          cmd_o.rd_off = OFF_CONT;
          state_d      = S_RHI;
        end
      end
      S_TRIM: begin
        cmd_o.ld_last = 1'b1;
        state_d       = S_FIN;
      end
      S_FIN: begin
        if (!stat_i.out_busy) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_disk_directory_file_size_walker_unit.sv @@
// self-checking testbench for the directory file-size walker: random chains, queries, stalls
`timescale 1ns / 100ps

module tb_disk_directory_file_size_walker_unit;
  import dfsw_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 7;
  localparam int TARGET_ITEMS    = 1350;
  localparam int MAX_GAP         = 6;
  localparam int HOLD_CYCLES     = 300;
  localparam int SETTLE_CYCLES   = 100;
  // idle limit for the watchdog, with room for several walks that run into the hop limit
  localparam int WATCHDOG_CYCLES = 40000;
  localparam longint unsigned SIZE_CAP = (64'd1 << SIZE_W) - 1;

  // how a generated file ends its chain
  typedef enum int {
    FILE_PLAIN,
    FILE_CHAIN,
    FILE_BAD_LINK,
    FILE_NOT_CONT,
    FILE_LOOP
  } file_shape_e;

  localparam int NUM_SHAPES = 5;

  // directory image, expected answers and error count
  class dir_size_board;
    bit [7:0]  image   [MEM_DEPTH];
    bit        written [MEM_DEPTH];
    out_item_t sizes_due [$];
    bit        saw_unwritten;
    int        errors;
    int        answers;

    function new();
      errors  = 0;
      answers = 0;
    endfunction

    function bit [7:0] peek(int e, int o);
      int a;
      a = e * ENTRY_BYTES + o;
      if (!written[a]) saw_unwritten = 1'b1;
      return image[a];
    endfunction

    // follow the extent chain of one entry and work out the answer
    function out_item_t walk_chain(int idx);
      out_item_t            r;
      int                   cur, pos, hops, nxt;
      logic [STATUS_W-1:0]  st;
      longint unsigned      total, trim;
      bit [7:0]             hi, lo, cnt, fl, tail;
      saw_unwritten = 1'b0;
      r = '0;
      if (idx >= ENTRIES) begin
        r.walk_status = WS_CORRUPT;
        return r;
      end
      cur   = idx;
      pos   = int'(FIRST_EXTENT);
      hops  = 0;
      st    = WS_OK;
      total = 0;
      while (1) begin
        hi  = peek(cur, pos);
        lo  = peek(cur, pos + 1);
        cnt = peek(cur, pos + 2);
        if (hi == 0 && lo == 0 && cnt == 0) break;
        total += 64'(cnt) * 64'(SECTOR_BYTES);
        pos   += int'(EXTENT_BYTES);
        if (pos > LAST_EXTENT) begin
          fl = peek(cur, FLAG_BYTE);
          if (!fl[FLAG_CONTINUED_BIT]) break;
          nxt = int'(peek(cur, LINK_BYTE));
          if (nxt >= ENTRIES) begin
            st = WS_CORRUPT;
            break;
          end
          fl = peek(nxt, FLAG_BYTE);
          if (!fl[FLAG_IS_CONT_BIT]) begin
            st = WS_CORRUPT;
            break;
          end
          if (hops >= ENTRIES) begin
            st = WS_HOPS;
            break;
          end
          hops++;
          cur = nxt;
          pos = int'(CONT_EXTENT);
        end
      end
      // last-sector byte count of the entry where the walk stopped, zero is a full sector
      tail = peek(cur, LINK_BYTE);
      if (tail != 0) begin
        trim  = 64'(SECTOR_BYTES - 32'(tail));
        total = (total > trim) ? total - trim : 0;
      end
      if (total > SIZE_CAP) total = SIZE_CAP;
      r.size_bytes  = total[SIZE_W-1:0];
      r.walk_status = st;
      r.entry_flags = peek(idx, FLAG_BYTE);
      return r;
    endfunction

    function bit query_is_defined(int idx);
      out_item_t dummy;
      dummy = walk_chain(idx);
      return !saw_unwritten;
    endfunction

    function int pending();
      return sizes_due.size();
    endfunction

    task flag_error(string msg);
      errors++;
      $display("[%0t] ERROR %s", $time, msg);
    endtask

    task take_request(in_item_t it);
      int a;
      if (it.action == ACT_WRITE) begin
        if (it.entry_index < ENTRIES && it.byte_offset < ENTRY_BYTES) begin
          a = it.entry_index * ENTRY_BYTES + it.byte_offset;
          image[a]   = it.byte_value;
          written[a] = 1'b1;
        end
      end else begin
        sizes_due.push_back(walk_chain(it.entry_index));
      end
    endtask

    task check_answer(out_item_t got);
      out_item_t want;
      answers++;
      if (sizes_due.size() == 0) begin
        flag_error($sformatf("answer %0d arrived with no query pending (size %0d status %0d)",
                             answers, got.size_bytes, got.walk_status));
        return;
      end
      want = sizes_due.pop_front();
      if (got.size_bytes !== want.size_bytes)
        flag_error($sformatf("answer %0d size_bytes got %0d want %0d",
                             answers, got.size_bytes, want.size_bytes));
      if (got.walk_status !== want.walk_status)
        flag_error($sformatf("answer %0d walk_status got %0d want %0d",
                             answers, got.walk_status, want.walk_status));
      if (got.entry_flags !== want.entry_flags)
        flag_error($sformatf("answer %0d entry_flags got %02h want %02h",
                             answers, got.entry_flags, want.entry_flags));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  dir_size_board board;
  int  file_heads [$];
  int  items_sent = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;
  bit  no_gaps = 1'b0;

  disk_directory_file_size_walker_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // sender: called at a falling edge, returns at the falling edge after acceptance
  // with valid still high, so a back-to-back item keeps it high
  task automatic send_item(input in_item_t it);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic go_quiet();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic put_byte(input int e, input int o, input int v);
    in_item_t it;
    it.action      = ACT_WRITE;
    it.entry_index = ENTRY_W'(e);
    it.byte_offset = 5'(o);
    it.byte_value  = 8'(v);
    send_item(it);
  endtask

  // a query whose walk would touch unwritten bytes becomes one past the end instead
  task automatic ask_size(input int idx);
    in_item_t it;
    if (idx < ENTRIES && !board.query_is_defined(idx)) idx = $urandom_range(ENTRIES, 255);
    it.action      = ACT_QUERY;
    it.entry_index = ENTRY_W'(idx);
    it.byte_offset = 5'($urandom_range(0, 31));
    it.byte_value  = 8'($urandom_range(0, 255));
    send_item(it);
  endtask

  function automatic int query_target();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10 || file_heads.size() == 0) return $urandom_range(ENTRIES, 255);
    if (r < 30) return $urandom_range(0, ENTRIES - 1);
    return file_heads[$urandom_range(0, file_heads.size() - 1)];
  endfunction

  // write a whole file: a head entry plus continuation entries, ending as the shape says
  task automatic build_file(input file_shape_e shape);
    int          n, pick, pos, first_pos, k, b, rot;
    int          ids [$];
    bit          clash;
    logic [7:0]  img [ENTRY_BYTES];
    logic [7:0]  flags;
    n = (shape == FILE_PLAIN) ? 1 :
        (shape == FILE_CHAIN) ? $urandom_range(2, 4) : $urandom_range(1, 3);
    while (ids.size() < n) begin
      pick  = $urandom_range(0, ENTRIES - 1);
      clash = 1'b0;
      foreach (ids[j]) if (ids[j] == pick) clash = 1'b1;
      if (!clash) ids.push_back(pick);
    end
    for (k = 0; k < n; k++) begin
      for (b = 0; b < ENTRY_BYTES; b++) img[b] = 8'($urandom_range(0, 255));
      flags = 8'($urandom_range(0, 255));
      if (k != 0) flags[FLAG_IS_CONT_BIT] = 1'b1;
      else if (shape == FILE_LOOP) flags[FLAG_IS_CONT_BIT] = 1'b1;
      else if (shape == FILE_NOT_CONT) flags[FLAG_IS_CONT_BIT] = 1'b0;
      // link or last-sector count
      if (k < n - 1) begin
        flags[FLAG_CONTINUED_BIT] = 1'b1;
        img[LINK_BYTE] = 8'(ids[k + 1]);
      end else begin
        case (shape)
          FILE_PLAIN, FILE_CHAIN: begin
            flags[FLAG_CONTINUED_BIT] = 1'b0;
            img[LINK_BYTE] = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
          end
          FILE_BAD_LINK: begin
            flags[FLAG_CONTINUED_BIT] = 1'b1;
            img[LINK_BYTE] = 8'($urandom_range(ENTRIES, 255));
          end
          default: begin
            // back to the head: a loop if the head carries the continuation mark
            flags[FLAG_CONTINUED_BIT] = 1'b1;
            img[LINK_BYTE] = 8'(ids[0]);
          end
        endcase
      end
      img[FLAG_BYTE] = flags;
      first_pos = (k == 0) ? int'(FIRST_EXTENT) : int'(CONT_EXTENT);
      for (pos = first_pos; pos <= LAST_EXTENT; pos += int'(EXTENT_BYTES)) begin
        if ((shape == FILE_PLAIN || shape == FILE_CHAIN) && pos + 2 < LINK_BYTE &&
            $urandom_range(0, 11) == 0) begin
          img[pos] = 8'h00; img[pos + 1] = 8'h00; img[pos + 2] = 8'h00;
        end else if (img[pos] == 0 && img[pos + 1] == 0 && img[pos + 2] == 0) begin
          img[pos] = 8'h01;
        end
      end
      rot = $urandom_range(0, ENTRY_BYTES - 1);
      for (b = 0; b < ENTRY_BYTES; b++)
        put_byte(ids[k], (rot + b) % ENTRY_BYTES, int'(img[(rot + b) % ENTRY_BYTES]));
    end
    file_heads.push_back(ids[0]);
    ask_size(ids[0]);
  endtask

  // monitor and watchdog, both sampled at the rising edge
  always @(posedge clk) begin
    if (rst_ni) begin
      if (in_valid && in_ready) board.take_request(in_item);
      if (out_valid && out_ready) board.check_answer(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("disk_directory_file_size_walker_unit: mismatch");
        $finish;
      end
    end
  end

  // receiver: random stall before each answer, a long hold when asked
  initial begin : answer_sink
    int stall;
    out_ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int          choice, builds, e, off, shape_r;
    bit          held, drained;
    file_shape_e shape;
    board    = new();
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    builds   = 0;
    held     = 1'b0;
    drained  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // directed: past-the-end queries and writes, a bare entry, underflow, one extent
    ask_size(255);
    ask_size(ENTRIES);
    put_byte(255, 31, 8'hFF);
    put_byte(0, ENTRY_BYTES, 8'h00);
    put_byte(159, FLAG_BYTE, 8'h00);
    put_byte(159, 12, 8'h00);
    put_byte(159, 13, 8'h00);
    put_byte(159, 14, 8'h00);
    put_byte(159, LINK_BYTE, 8'h00);
    ask_size(159);
    // trim bigger than the empty file clamps to zero
    put_byte(159, LINK_BYTE, 8'h80);
    ask_size(159);
    put_byte(158, FLAG_BYTE, 8'hDE);
    put_byte(158, 12, 8'h00);
    put_byte(158, 13, 8'h01);
    put_byte(158, 14, 8'hFF);
    put_byte(158, 15, 8'h00);
    put_byte(158, 16, 8'h00);
    put_byte(158, 17, 8'h00);
    put_byte(158, LINK_BYTE, 8'h00);
    ask_size(158);
    put_byte(0, FLAG_BYTE, 8'hFF);

    // random: files of every shape first, then a weighted mix
    while (items_sent < TARGET_ITEMS) begin
      no_gaps = (items_sent >= 1000 && items_sent < 1150);
      if (!held && items_sent >= 400) begin
        // receiver stops for a while so the block backs up and stalls its input
        held     = 1'b1;
        hold_req = 1'b1;
        repeat (10) ask_size(query_target());
      end
      if (!drained && items_sent >= 800) begin
        drained = 1'b1;
        go_quiet();
        while (board.pending() != 0) @(negedge clk);
      end
      choice = $urandom_range(0, 99);
      if (builds < NUM_SHAPES || choice < 8) begin
        shape_r = $urandom_range(0, 99);
        if (builds < NUM_SHAPES) shape = file_shape_e'(builds);
        else if (shape_r < 30) shape = FILE_PLAIN;
        else if (shape_r < 70) shape = FILE_CHAIN;
        else if (shape_r < 80) shape = FILE_BAD_LINK;
        else if (shape_r < 90) shape = FILE_NOT_CONT;
        else shape = FILE_LOOP;
        build_file(shape);
        builds++;
      end else if (choice < 68) begin
        ask_size(query_target());
      end else if (choice < 90) begin
        // overwrite one byte, mostly flags, links and extents of known files
        e = (file_heads.size() > 0 && $urandom_range(0, 1))
            ? file_heads[$urandom_range(0, file_heads.size() - 1)]
            : $urandom_range(0, ENTRIES - 1);
        case ($urandom_range(0, 3))
          0:       off = int'(FLAG_BYTE);
          1:       off = int'(LINK_BYTE);
          default: off = $urandom_range(0, ENTRY_BYTES - 1);
        endcase
        put_byte(e, off, $urandom_range(0, 255));
      end else if ($urandom_range(0, 1)) begin
        put_byte($urandom_range(ENTRIES, 255), $urandom_range(0, 31), $urandom_range(0, 255));
      end else begin
        put_byte($urandom_range(0, ENTRIES - 1), $urandom_range(ENTRY_BYTES, 31),
                 $urandom_range(0, 255));
      end
    end

    no_gaps = 1'b0;
    go_quiet();
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (board.errors == 0) $display("disk_directory_file_size_walker_unit: match");
    else $display("disk_directory_file_size_walker_unit: mismatch");
    $finish;
  end

endmodule

@@ disk_directory_file_size_walker_unit.f @@
design/dfsw_pkg.sv
design/dfsw_datapath.sv
design/dfsw_ctrl.sv
design/disk_directory_file_size_walker_unit.sv
dv/tb_disk_directory_file_size_walker_unit.sv
